>>> hw/rtl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg: shared types and constants of the Cartesian to spherical converter
// Holds the pipeline widths, the CORDIC arctangent table and the step
// functions used by the integer square root and CORDIC vectoring stages.
// ----------------------------------------------------------------------------
package c2s_pkg;

  // Number of CORDIC micro-rotations; at most 24 are used.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned ROOT_W     = 48;
  localparam int unsigned ROOT_STEPS = ROOT_W / 2;
  localparam int unsigned CV_W       = 36;
  localparam int unsigned ACC_W      = 34;

  localparam logic signed [ACC_W-1:0] ACC_QUARTER = 34'sd1073741824;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic signed [ACC_W-1:0] ATAN_TAB [24] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] res;
  } sq_t;

  typedef struct packed {
    sq_t pl;   // root of the planar square sum, scaled by 2^8
    sq_t sp;   // root of the full square sum
  } rt_t;

  typedef struct packed {
    logic signed [CV_W-1:0]  a;
    logic signed [CV_W-1:0]  b;
    logic signed [ACC_W-1:0] acc;
  } cv_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      org;
    logic                      axis;
    logic [COORD_W-1:0]        radius;
  } meta_t;

  // One digit of the restoring square root; the trial bit walks down by 4x.
  function automatic sq_t sqrt_step(sq_t cur, int unsigned k);
    logic [ROOT_W-1:0] bit_v;
    logic [ROOT_W-1:0] trial;
    sq_t               nxt;
    bit_v = {{(ROOT_W-1){1'b0}}, 1'b1} << (ROOT_W - 2 - 2 * k);
    trial = cur.res + bit_v;
    if (cur.rem >= trial) begin
      nxt.rem = cur.rem - trial;
      nxt.res = (cur.res >> 1) + bit_v;
    end else begin
      nxt.rem = cur.rem;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

  // Folds the left half plane onto the right half plane by a quarter turn.
  function automatic cv_t cordic_prerot(logic signed [CV_W-1:0] a,
                                        logic signed [CV_W-1:0] b);
    cv_t nxt;
    if (a[CV_W-1]) begin
      if (!b[CV_W-1]) begin
        nxt.a   = b;
        nxt.b   = -a;
        nxt.acc = ACC_QUARTER;
      end else begin
        nxt.a   = -b;
        nxt.b   = a;
        nxt.acc = -ACC_QUARTER;
      end
    end else begin
      nxt.a   = a;
      nxt.b   = b;
      nxt.acc = '0;
    end
    return nxt;
  endfunction

  // One vectoring micro-rotation that drives b toward zero.
  function automatic cv_t cordic_step(cv_t cur, int unsigned i);
    logic signed [CV_W-1:0] da;
    logic signed [CV_W-1:0] db;
    cv_t                    nxt;
    da = cur.b >>> i;
    db = cur.a >>> i;
    if (!cur.b[CV_W-1]) begin
      nxt.a   = cur.a + da;
      nxt.b   = cur.b - db;
      nxt.acc = cur.acc + ATAN_TAB[5'(i)];
    end else begin
      nxt.a   = cur.a - da;
      nxt.b   = cur.b + db;
      nxt.acc = cur.acc - ATAN_TAB[5'(i)];
    end
    return nxt;
  endfunction

endpackage

>>> hw/rtl/cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical: streaming Cartesian to spherical converter
// Converts signed 16-bit (x, y, z) points into radius, azimuth and polar angle
// with binary angle units (32768 stands for pi).
// ----------------------------------------------------------------------------
// Usage: points enter on the s_axis channel, one request per point, and
// results leave on the m_axis channel in the same order, one per point.
// The datapath is a single pipeline of CORDIC_N + 28 register stages:
// squares, square sums, 24 one-digit square root stages, a quadrant fold
// with radius rounding, CORDIC_N micro-rotation stages for both angles in
// parallel, and the output register. A new point is taken in every cycle
// unless a result is held back, so throughput is one point per cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready_o drops in the same cycle; no request is lost or
// repeated. Reset clears all valid bits; the first point can be taken in the
// cycle after reset is released. The origin reports radius and both angles
// as zero with the at_origin flag set in m_axis_tuser_o.
// ----------------------------------------------------------------------------
module cartesian_to_spherical (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // coord_x [15:0], coord_y [31:16], coord_z [47:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // radius [15:0], azimuth [31:16], polar [47:32]
  output logic        m_axis_tuser_o    // at_origin [0]
);
  import c2s_pkg::*;

  localparam int unsigned ST_ROOT = 1;
  localparam int unsigned ST_PREP = ST_ROOT + ROOT_STEPS + 1;
  localparam int unsigned ST_OUT  = ST_PREP + CORDIC_N + 1;
  localparam int unsigned DEPTH   = ST_OUT + 1;

  logic             en;
  logic [DEPTH-1:0] vld_q;

  logic [30:0] sq_x_q, sq_y_q, sq_z_q;
  meta_t       meta_q [ST_OUT];
  rt_t         rt_q   [ROOT_STEPS+1];
  cv_t         caz_q  [CORDIC_N+1];
  cv_t         cpo_q  [CORDIC_N+1];

  logic [COORD_W-1:0]        radius_q;
  logic signed [COORD_W-1:0] azimuth_q;
  logic [COORD_W-1:0]        polar_q;
  logic                      origin_q;

  // The whole pipeline advances unless a finished result is held back.
  assign en              = !vld_q[DEPTH-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid_i};
    end
  end

  // Stage 0: squares of the coordinates.
  logic signed [COORD_W-1:0] in_x, in_y, in_z;
  logic signed [31:0]        mul_x, mul_y, mul_z;
  meta_t                     meta_in;

  always_comb begin
    in_x           = s_axis_tdata_i[15:0];
    in_y           = s_axis_tdata_i[31:16];
    in_z           = s_axis_tdata_i[47:32];
    mul_x          = 32'(in_x) * 32'(in_x);
    mul_y          = 32'(in_y) * 32'(in_y);
    mul_z          = 32'(in_z) * 32'(in_z);
    meta_in        = '0;
    meta_in.x      = in_x;
    meta_in.y      = in_y;
    meta_in.z      = in_z;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_x_q    <= mul_x[30:0];
      sq_y_q    <= mul_y[30:0];
      sq_z_q    <= mul_z[30:0];
      meta_q[0] <= meta_in;
    end
  end

  // Stage 1: square sums load the two root units.
  logic [31:0] pl2, s2;
  rt_t         rt_in;
  meta_t       meta_st1;

  always_comb begin
    pl2            = {1'b0, sq_x_q} + {1'b0, sq_y_q};
    s2             = pl2 + {1'b0, sq_z_q};
    rt_in.pl.rem   = {pl2, 16'b0};
    rt_in.pl.res   = '0;
    rt_in.sp.rem   = {16'b0, s2};
    rt_in.sp.res   = '0;
    meta_st1       = meta_q[0];
    meta_st1.org   = (meta_q[0].x == '0) && (meta_q[0].y == '0) && (meta_q[0].z == '0);
    meta_st1.axis  = (meta_q[0].x == '0) && (meta_q[0].y == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_q[0]         <= rt_in;
      meta_q[ST_ROOT] <= meta_st1;
    end
  end

  // Square root stages, one result bit each.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_q[k+1].pl      <= sqrt_step(rt_q[k].pl, k);
        rt_q[k+1].sp      <= sqrt_step(rt_q[k].sp, k);
        meta_q[ST_ROOT+k+1] <= meta_q[ST_ROOT+k];
      end
    end
  end

  // Prep stage: round the radius and fold both vectors into the right half.
  logic [COORD_W-1:0]     r_floor;
  logic [23:0]            rho;
  logic signed [CV_W-1:0] az_a, az_b, po_a, po_b;
  meta_t                  meta_prep;

  always_comb begin
    r_floor          = rt_q[ROOT_STEPS].sp.res[COORD_W-1:0];
    rho              = rt_q[ROOT_STEPS].pl.res[23:0];
    meta_prep        = meta_q[ST_PREP-1];
    // Round to nearest: the remainder exceeds r exactly when the root is past r + 1/2.
    meta_prep.radius = (rt_q[ROOT_STEPS].sp.rem > {{(ROOT_W-COORD_W){1'b0}}, r_floor})
                       ? r_floor + 16'd1 : r_floor;
    az_a = {{(CV_W-32){meta_prep.x[COORD_W-1]}}, meta_prep.x, 16'b0};
    az_b = {{(CV_W-32){meta_prep.y[COORD_W-1]}}, meta_prep.y, 16'b0};
    po_a = {{(CV_W-32){meta_prep.z[COORD_W-1]}}, meta_prep.z, 16'b0};
    po_b = {{(CV_W-32){1'b0}}, rho, 8'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      caz_q[0]        <= cordic_prerot(az_a, az_b);
      cpo_q[0]        <= cordic_prerot(po_a, po_b);
      meta_q[ST_PREP] <= meta_prep;
    end
  end

  // CORDIC vectoring stages for azimuth and polar angle side by side.
  for (genvar j = 0; j < CORDIC_N; j++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en) begin
        caz_q[j+1]          <= cordic_step(caz_q[j], j);
        cpo_q[j+1]          <= cordic_step(cpo_q[j], j);
        meta_q[ST_PREP+j+1] <= meta_q[ST_PREP+j];
      end
    end
  end

  // Output stage: round the angles and apply the axis and origin cases.
  logic signed [ACC_W:0]     az_sum, po_sum;
  logic signed [ACC_W-16:0]  po_ang;
  logic signed [COORD_W-1:0] azimuth_d;
  logic [COORD_W-1:0]        polar_d;
  meta_t                     meta_fin;

  always_comb begin
    meta_fin = meta_q[ST_OUT-1];
    az_sum   = {caz_q[CORDIC_N].acc[ACC_W-1], caz_q[CORDIC_N].acc} + 35'sd32768;
    po_sum   = {cpo_q[CORDIC_N].acc[ACC_W-1], cpo_q[CORDIC_N].acc} + 35'sd32768;
    po_ang   = po_sum[ACC_W:16];
    if (meta_fin.org) begin
      azimuth_d = '0;
      polar_d   = '0;
    end else if (meta_fin.axis) begin
      azimuth_d = '0;
      polar_d   = meta_fin.z[COORD_W-1] ? 16'd32768 : 16'd0;
    end else begin
      // An azimuth of +pi wraps to -pi through the 16-bit truncation.
      azimuth_d = az_sum[31:16];
      if (po_ang[ACC_W-16]) begin
        polar_d = '0;
      end else if (po_ang > 19'sd32768) begin
        polar_d = 16'd32768;
      end else begin
        polar_d = po_ang[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      radius_q  <= meta_fin.radius;
      azimuth_q <= azimuth_d;
      polar_q   <= polar_d;
      origin_q  <= meta_fin.org;
    end
  end

  assign m_axis_tvalid_o = vld_q[DEPTH-1];
  assign m_axis_tdata_o  = {polar_q, azimuth_q, radius_q};
  assign m_axis_tuser_o  = origin_q;

`ifndef SYNTHESIS
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 48'd0)
    else $error("origin result carries nonzero radius or angle");

  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[47:32] <= 16'd32768)
    else $error("polar angle above pi");

  a_radius_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:0] <= 16'd56756)
    else $error("radius out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a held result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");
`endif

endmodule

>>> tb/sv/cartesian_to_spherical_checker.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_checker: result predictor and scoreboard
// Watches both stream channels of the converter. For every accepted point it
// computes the expected radius, azimuth, polar angle and origin flag in
// integer arithmetic. It then compares each returned result with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  import c2s_pkg::*;

  typedef struct packed {
    logic [15:0]        radius;
    logic signed [15:0] azimuth;
    logic [15:0]        polar;
    logic               at_origin;
  } sph_t;

  // Arctangent of 2^-i in units where pi is 2^31.
  localparam longint ARCTAN_UNITS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  sph_t        spherical_q[$];
  int unsigned fail_count = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Four-quadrant angle of the vector (re, im), rounded to pi/32768 units.
  function automatic longint vector_bam(longint re, longint im);
    longint acc;
    longint tmp;
    longint d_re;
    longint d_im;
    int     i;
    acc = 0;
    if (re < 0) begin
      tmp = re;
      if (im >= 0) begin
        re  = im;
        im  = -tmp;
        acc = 64'sd1 << 30;
      end else begin
        re  = -im;
        im  = tmp;
        acc = -(64'sd1 << 30);
      end
    end
    for (i = 0; i < int'(CORDIC_N); i++) begin
      d_re = im >>> i;
      d_im = re >>> i;
      if (im >= 0) begin
        re  = re + d_re;
        im  = im - d_im;
        acc = acc + ARCTAN_UNITS[5'(i)];
      end else begin
        re  = re - d_re;
        im  = im + d_im;
        acc = acc - ARCTAN_UNITS[5'(i)];
      end
    end
    return (acc + 32768) >>> 16;
  endfunction

  function automatic sph_t predict_spherical(logic [47:0] point);
    longint          px;
    longint          py;
    longint          pz;
    longint          rho;
    longint          az;
    longint          po;
    longint unsigned plane_sq;
    longint unsigned full_sq;
    longint unsigned root;
    sph_t            res;
    px       = signed'(point[15:0]);
    py       = signed'(point[31:16]);
    pz       = signed'(point[47:32]);
    plane_sq = px * px + py * py;
    full_sq  = plane_sq + longint'(pz * pz);
    root     = int_sqrt(full_sq);
    if (full_sq - root * root > root) root++;
    az            = 0;
    po            = 0;
    res.at_origin = 1'b0;
    if (full_sq == 0) begin
      res.at_origin = 1'b1;
    end else if (plane_sq == 0) begin
      po = (pz > 0) ? 0 : 32768;
    end else begin
      // The planar radius carries 8 fraction bits, then gets the same 2^16 scale.
      rho = longint'(int_sqrt(plane_sq << 16));
      az  = vector_bam(px * 65536, py * 65536);
      po  = vector_bam(pz * 65536, rho * 256);
      if (po < 0) po = 0;
      if (po > 32768) po = 32768;
    end
    res.radius  = root[15:0];
    res.azimuth = az[15:0];
    res.polar   = po[15:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    sph_t got;
    sph_t want;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tdata_i[15:0], m_tdata_i[31:16], m_tdata_i[47:32], m_tuser_i};
        if (spherical_q.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result: radius %0d azimuth %0d polar %0d origin %0b",
                     $realtime, got.radius, got.azimuth, got.polar, got.at_origin);
          fail_count++;
        end else begin
          want = spherical_q.pop_front();
          if (got.radius !== want.radius || got.azimuth !== want.azimuth ||
              got.polar !== want.polar || got.at_origin !== want.at_origin) begin
            if (fail_count < 10)
              $display("[%0t] mismatch r %0d/%0d az %0d/%0d po %0d/%0d org %0b/%0b (exp/act)",
                       $realtime, want.radius, got.radius, want.azimuth, got.azimuth,
                       want.polar, got.polar, want.at_origin, got.at_origin);
            fail_count++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) spherical_q.push_back(predict_spherical(s_tdata_i));
    end
    mismatches_o  <= fail_count;
    outstanding_o <= spherical_q.size();
  end

endmodule

>>> tb/sv/cartesian_to_spherical_tb.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_tb: stream testbench of the spherical converter
// Sends directed corner points (origin, axes, the azimuth wrap at pi, extreme
// coordinates, rounding cases) and then random points in bursts. Meanwhile the
// result side stalls in changing patterns. A separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_tb;

  localparam int          RANDOM_POINTS = 1200;
  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          DRAIN_CYCLES  = 60;
  localparam logic [15:0] EXTREME_VALS [7] = '{
    16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 1;
  int unsigned ready_mode  = 0;
  int unsigned ready_tick  = 0;

  always #10 clk_i = ~clk_i;

  cartesian_to_spherical u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  cartesian_to_spherical_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready_o),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata_o),
    .m_tuser_i     (m_axis_tuser_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cartesian_to_spherical verification failed");
      $finish;
    end
  end

  // The receiver switches between randomly chosen stall patterns.
  always @(posedge clk_i) begin
    ready_tick++;
    if (ready_tick % 200 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (ready_tick % 9) < 4;
    endcase
  end

  // Presents one point and holds it until taken; a burst may end with a gap.
  task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
    int unsigned gap;
    s_axis_tdata  <= {z, y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [15:0] near_zero(int span);
    return 16'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [15:0] any_extreme();
    return EXTREME_VALS[3'($urandom_range(0, 6))];
  endfunction

  task automatic send_random_point();
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    x = 16'($urandom);
    y = 16'($urandom);
    z = 16'($urandom);
    case ($urandom_range(0, 9))
      4: begin
        x = near_zero(8);
        y = near_zero(8);
        z = near_zero(8);
      end
      5: begin
        // Points on an axis or in a coordinate plane.
        if ($urandom_range(0, 1)) x = '0;
        if ($urandom_range(0, 1)) y = '0;
        if ($urandom_range(0, 1)) z = '0;
      end
      6: begin
        x = any_extreme();
        y = any_extreme();
        z = any_extreme();
      end
      7: begin
        x = near_zero(3);
        y = near_zero(3);
      end
      8: begin
        // Close to the negative x axis, where the azimuth wraps around pi.
        x = 16'h8000 | 16'($urandom_range(0, 32767));
        y = near_zero(4);
      end
      default: ;
    endcase
    send_point(x, y, z);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point(16'd0, 16'd0, 16'd0);
    send_point(16'd0, 16'd0, 16'd1);
    send_point(16'd0, 16'd0, 16'hFFFF);
    send_point(16'd0, 16'd0, 16'h7FFF);
    send_point(16'd0, 16'd0, 16'h8000);
    send_point(16'd1, 16'd0, 16'd0);
    send_point(16'hFFFF, 16'd0, 16'd0);
    send_point(16'h8000, 16'd0, 16'd0);
    send_point(16'h8000, 16'hFFFF, 16'd0);
    send_point(16'd0, 16'd1, 16'd0);
    send_point(16'd0, 16'hFFFF, 16'd0);
    send_point(16'd1, 16'd1, 16'd1);
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7FFF, 16'h8000, 16'd0);
    send_point(16'd1, 16'd0, 16'h7FFF);
    send_point(16'd1, 16'd0, 16'h8000);
    send_point(16'h8000, 16'h7FFF, 16'hFFFF);
    send_point(16'd0, 16'h7FFF, 16'h8000);
    send_point(16'd3, 16'd4, 16'd0);
    send_point(16'd2, 16'd1, 16'd1);
    send_point(16'd2, 16'd2, 16'd2);
    send_point(16'd5, 16'd5, 16'd0);

    repeat (RANDOM_POINTS) send_random_point();
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("cartesian_to_spherical verification clean");
    end else begin
      $display("cartesian_to_spherical verification failed");
    end
    $finish;
  end

endmodule
